### rtl/lpfr_pkg.sv
// Shared types and constants for the length-prefixed frame receiver.
package lpfr_pkg;

  localparam int unsigned PREFIX_BYTES = 4;
  localparam int unsigned HCNT_W       = 3;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned BYTE_W       = 8;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 32'd4096;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_DONE    = 4'b0100,
    PH_ERROR   = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_NEED_MORE = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_INVALID   = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic              chunk_last;
  } item_t;

  typedef struct packed {
    logic              status_valid;
    logic [1:0]        status;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_last;
    logic [LEN_W-1:0]  payload_length;
  } res_t;

endpackage

### rtl/lpfr_ifs.sv
// Channel interfaces: byte input, result output and configuration write.
interface lpfr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, kind, data_byte, chunk_last, input ready);
  modport sink (input valid, kind, data_byte, chunk_last, output ready);
endinterface

interface lpfr_out_if;
  logic        valid;
  logic        ready;
  logic        status_valid;
  logic [1:0]  status;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [31:0] payload_length;

  modport source (output valid, status_valid, status, payload_valid, payload_byte,
                  payload_last, payload_length, input ready);
  modport sink (input valid, status_valid, status, payload_valid, payload_byte,
                payload_last, payload_length, output ready);
endinterface

interface lpfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/lpfr_core.sv
// Frame state tracking: header assembly, length checks, payload count, chunk status.
module lpfr_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  lpfr_pkg::item_t                   item,
  input  logic                              cfg_we,
  input  logic [lpfr_pkg::LEN_W-1:0]        cfg_data,
  output lpfr_pkg::res_t                    res
);
  import lpfr_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [HCNT_W-1:0]  hcnt_r, hcnt_nxt;
  logic [LEN_W-1:0]   decl_len_r, decl_len_nxt;
  logic [LEN_W-1:0]   pcnt_r, pcnt_nxt;
  status_t            pend_err_r, pend_err_nxt;
  logic               rej_r, rej_nxt;
  logic               at_start_r, at_start_nxt;
  logic [LEN_W-1:0]   max_payload_r;
  logic               rej;
  status_t            st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hcnt_r     <= '0;
      decl_len_r <= '0;
      pcnt_r     <= '0;
      pend_err_r <= ST_NEED_MORE;
      rej_r      <= 1'b0;
      at_start_r <= 1'b1;
    end else begin
      phase_r    <= phase_nxt;
      hcnt_r     <= hcnt_nxt;
      decl_len_r <= decl_len_nxt;
      pcnt_r     <= pcnt_nxt;
      pend_err_r <= pend_err_nxt;
      rej_r      <= rej_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    hcnt_nxt     = hcnt_r;
    decl_len_nxt = decl_len_r;
    pcnt_nxt     = pcnt_r;
    pend_err_nxt = pend_err_r;
    rej_nxt      = rej_r;
    at_start_nxt = at_start_r;
    rej          = rej_r;
    st           = ST_NEED_MORE;
    res          = '0;

    if (accept) begin
      if (item.kind == KIND_CLEAR) begin
        phase_nxt    = PH_HEADER;
        hcnt_nxt     = '0;
        decl_len_nxt = '0;
        pcnt_nxt     = '0;
        pend_err_nxt = ST_NEED_MORE;
        rej_nxt      = 1'b0;
        at_start_nxt = 1'b1;
      end else begin
        // first byte of a chunk decides whether the whole chunk is dropped
        if (at_start_r) begin
          rej          = (phase_r == PH_DONE) || (phase_r == PH_ERROR);
          rej_nxt      = rej;
          at_start_nxt = 1'b0;
        end

        if (!rej) begin
          case (phase_r)
            PH_HEADER: begin
              decl_len_nxt = decl_len_r |
                             (LEN_W'(item.data_byte) << {hcnt_r[1:0], 3'b000});
              hcnt_nxt     = hcnt_r + HCNT_W'(1);
              if (hcnt_nxt >= HCNT_W'(PREFIX_BYTES)) begin
                if (decl_len_nxt == '0) begin
                  phase_nxt    = PH_ERROR;
                  pend_err_nxt = ST_INVALID;
                end else if (decl_len_nxt > max_payload_r) begin
                  phase_nxt    = PH_ERROR;
                  pend_err_nxt = ST_TOO_LARGE;
                end else begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
            PH_PAYLOAD: begin
              res.payload_valid = 1'b1;
              res.payload_byte  = item.data_byte;
              pcnt_nxt          = pcnt_r + LEN_W'(1);
              if (pcnt_nxt >= decl_len_r) begin
                res.payload_last = 1'b1;
                phase_nxt        = PH_DONE;
              end
            end
            default: ;
          endcase
        end

        if (item.chunk_last) begin
          res.status_valid = 1'b1;
          if (rej) begin
            st = ST_INVALID;
          end else if (phase_nxt == PH_ERROR) begin
            st = pend_err_nxt;
          end else if (phase_nxt == PH_DONE) begin
            st = ST_COMPLETE;
          end else begin
            st = ST_NEED_MORE;
          end
          at_start_nxt = 1'b1;
        end
        res.status         = st;
        res.payload_length = (phase_nxt == PH_DONE) ? decl_len_nxt : '0;
      end
    end
  end

endmodule

### rtl/lpfr_skid.sv
// Two-entry output buffer: result register plus skid register.
module lpfr_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lpfr_pkg::res_t  push_data,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lpfr_pkg::res_t  out_data
);
  import lpfr_pkg::*;

  res_t out_data_r;
  res_t skid_data_r;
  logic out_valid_r;
  logic skid_valid_r;

  assign push_ready = ~skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || out_ready) begin
        out_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

endmodule

### rtl/length_prefixed_frame_receiver.sv
// Top level of the length-prefixed frame receiver.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+--------------------------------------------
//   in_chan  | in  | valid/ready   | kind, data_byte, chunk_last
//   out_chan | out | valid/ready   | status_valid, status, payload_valid,
//            |     |               | payload_byte, payload_last, payload_length
//   cfg_chan | in  | valid/ready   | data = max_payload (always ready)
//
// One result per byte transaction; one byte accepted per cycle while in_chan.ready
// is high. Frame state updates on the accepting edge; the result is registered in
// the output register, or in the skid register if the output stalls. The skid
// register holds one extra result, so in_chan.ready drops only when two results
// wait. rst_n is synchronous, active low; it restores the frame to idle and max_payload to 4096.
module length_prefixed_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  lpfr_in_if.sink     in_chan,
  lpfr_out_if.source  out_chan,
  lpfr_cfg_if.sink    cfg_chan
);
  import lpfr_pkg::*;

  item_t item;
  res_t  res;
  res_t  out_res;
  logic  accept;
  logic  push_ready;

  assign item.kind       = in_chan.kind;
  assign item.data_byte  = in_chan.data_byte;
  assign item.chunk_last = in_chan.chunk_last;

  assign in_chan.ready  = push_ready;
  assign accept         = in_chan.valid & push_ready;
  assign cfg_chan.ready = 1'b1;

  lpfr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (item),
    .cfg_we   (cfg_chan.valid),
    .cfg_data (cfg_chan.data),
    .res      (res)
  );

  lpfr_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (push_ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_data   (out_res)
  );

  assign out_chan.status_valid   = out_res.status_valid;
  assign out_chan.status         = out_res.status;
  assign out_chan.payload_valid  = out_res.payload_valid;
  assign out_chan.payload_byte   = out_res.payload_byte;
  assign out_chan.payload_last   = out_res.payload_last;
  assign out_chan.payload_length = out_res.payload_length;

endmodule

### rtl/lpfr_chk.sv
// Port-level assertions for the frame receiver, bound to the top level.
module lpfr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status_valid,
  input logic [1:0]  status,
  input logic        payload_valid,
  input logic        payload_last,
  input logic [31:0] payload_length
);
  import lpfr_pkg::*;

  // last mark only rides on a real payload byte
  a_last_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && payload_last |-> payload_valid)
    else $error("payload_last without payload_valid");

  // status is zero unless a chunk ended
  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !status_valid |-> status == ST_NEED_MORE)
    else $error("status nonzero without status_valid");

  // the final byte completes the frame, so its length is reported
  a_last_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && payload_last |-> payload_length != 32'd0)
    else $error("frame completed with zero payload_length");

  a_out_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind length_prefixed_frame_receiver lpfr_chk u_lpfr_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .status_valid   (out_chan.status_valid),
  .status         (out_chan.status),
  .payload_valid  (out_chan.payload_valid),
  .payload_last   (out_chan.payload_last),
  .payload_length (out_chan.payload_length)
);

### verif/lpfr_checker.sv
// Checker for the frame receiver: predicts each result from the accepted bytes and compares.
module lpfr_checker (
  input  logic clk,
  input  logic rst_n,
  lpfr_in_if   in_mon,
  lpfr_out_if  out_mon,
  lpfr_cfg_if  cfg_mon,
  output int   fail_count,
  output int   outstanding,
  output int   n_results,
  output int   n_payload,
  output int   n_frames,
  output int   n_invalid,
  output int   n_too_large
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpfr_pkg::*;

  logic [LEN_W-1:0]  max_payload;
  phase_t            ph;
  logic [HCNT_W-1:0] hdr_count;
  logic [LEN_W-1:0]  decl_len;
  logic [LEN_W-1:0]  pay_count;
  status_t           err_code;
  logic              chunk_rejected;
  logic              chunk_start;
  res_t              pending_results[$];

  function automatic void frame_clear();
    ph             = PH_HEADER;
    hdr_count      = '0;
    decl_len       = '0;
    pay_count      = '0;
    err_code       = ST_NEED_MORE;
    chunk_rejected = 1'b0;
    chunk_start    = 1'b1;
  endfunction

  // Advances the frame state by one byte transaction and returns the result it causes.
  function automatic res_t deframe_step(input item_t it);
    res_t r;
    r = '0;
    if (it.kind == KIND_CLEAR) begin
      frame_clear();
      return r;
    end
    // a chunk is judged by the state at its first byte
    if (chunk_start) begin
      chunk_rejected = (ph == PH_DONE) || (ph == PH_ERROR);
      chunk_start = 1'b0;
    end
    if (!chunk_rejected) begin
      if (ph == PH_HEADER) begin
        decl_len |= LEN_W'(it.data_byte) << (8 * hdr_count[1:0]);
        hdr_count = hdr_count + HCNT_W'(1);
        if (hdr_count >= HCNT_W'(PREFIX_BYTES)) begin
          if (decl_len == '0) begin
            ph = PH_ERROR;
            err_code = ST_INVALID;
          end else if (decl_len > max_payload) begin
            ph = PH_ERROR;
            err_code = ST_TOO_LARGE;
          end else begin
            ph = PH_PAYLOAD;
          end
        end
      end else if (ph == PH_PAYLOAD) begin
        r.payload_valid = 1'b1;
        r.payload_byte  = it.data_byte;
        pay_count = pay_count + LEN_W'(1);
        if (pay_count >= decl_len) begin
          r.payload_last = 1'b1;
          ph = PH_DONE;
        end
      end
    end
    if (it.chunk_last) begin
      r.status_valid = 1'b1;
      if (chunk_rejected)
        r.status = ST_INVALID;
      else if (ph == PH_ERROR)
        r.status = err_code;
      else if (ph == PH_DONE)
        r.status = ST_COMPLETE;
      else
        r.status = ST_NEED_MORE;
      chunk_start = 1'b1;
    end
    if (ph == PH_DONE)
      r.payload_length = decl_len;
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 200)
        $display("t=%0t %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t  want;
    res_t  got;
    item_t it;
    if (!rst_n) begin
      max_payload = MAX_PAYLOAD_RST;
      frame_clear();
      pending_results.delete();
      fail_count  = 0;
      n_results   = 0;
      n_payload   = 0;
      n_frames    = 0;
      n_invalid   = 0;
      n_too_large = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        max_payload = cfg_mon.data;
      if (out_mon.valid && out_mon.ready) begin
        got.status_valid   = out_mon.status_valid;
        got.status         = out_mon.status;
        got.payload_valid  = out_mon.payload_valid;
        got.payload_byte   = out_mon.payload_byte;
        got.payload_last   = out_mon.payload_last;
        got.payload_length = out_mon.payload_length;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("t=%0t unexpected result: expected none, actual sv=%0b st=%0d pv=%0b",
                   $time, got.status_valid, got.status, got.payload_valid);
        end else begin
          want = pending_results.pop_front();
          n_results++;
          cmp_field("status_valid", 32'(want.status_valid), 32'(got.status_valid));
          cmp_field("status", 32'(want.status), 32'(got.status));
          cmp_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
          cmp_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
          cmp_field("payload_last", 32'(want.payload_last), 32'(got.payload_last));
          cmp_field("payload_length", want.payload_length, got.payload_length);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it.kind       = in_mon.kind;
        it.data_byte  = in_mon.data_byte;
        it.chunk_last = in_mon.chunk_last;
        want = deframe_step(it);
        pending_results.push_back(want);
        if (want.payload_valid) n_payload++;
        if (want.payload_last) n_frames++;
        if (want.status_valid && want.status == ST_INVALID) n_invalid++;
        if (want.status_valid && want.status == ST_TOO_LARGE) n_too_large++;
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

### verif/tb_top.sv
// Testbench top: clock, reset, byte and max_payload stimulus, receiver stalls and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lpfr_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 170;

  logic        clk;
  logic        rst_n;
  int          items_sent;
  int          clears_sent;
  int          cfg_writes;
  int          cycle_count;
  logic [31:0] cur_max;
  bit          no_gaps;
  bit          rx_hold;

  int fail_count, outstanding, n_results, n_payload, n_frames, n_invalid, n_too_large;

  lpfr_in_if  in_chan ();
  lpfr_out_if out_chan ();
  lpfr_cfg_if cfg_chan ();

  length_prefixed_frame_receiver uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  lpfr_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_mon     (cfg_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .n_results   (n_results),
    .n_payload   (n_payload),
    .n_frames    (n_frames),
    .n_invalid   (n_invalid),
    .n_too_large (n_too_large)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(12, 30);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic int ready_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(10, 40);
    return $urandom_range(60, 200);
  endfunction

  // valid stays high after a transaction, so back-to-back bytes keep it asserted without a gap
  task automatic offer(input logic k, input logic [7:0] b, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= k;
    in_chan.data_byte  <= b;
    in_chan.chunk_last <= l;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (k == KIND_CLEAR) clears_sent++;
  endtask

  task automatic push_data(input logic [7:0] b, input logic l);
    offer(KIND_DATA, b, l);
  endtask

  task automatic push_clear();
    offer(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_payload(input logic [31:0] v);
    settle();
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= v;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    cur_max = v;
    cfg_writes++;
  endtask

  // One frame, mostly well formed with random chunking; some noise, bad lengths and cut frames.
  task automatic random_frame();
    int unsigned roll;
    int unsigned cap;
    int unsigned n_pay;
    int unsigned surplus;
    logic [31:0] len;
    bit          bad;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      n_pay = $urandom_range(1, 12);
      repeat (n_pay) begin
        if ($urandom_range(0, 9) == 0)
          push_clear();
        else
          push_data(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      return;
    end
    bad = 1'b1;
    if (roll < 14) begin
      len = '0;
    end else if ((roll < 22 || cur_max == '0) && cur_max != '1) begin
      len = $urandom();
      if ($urandom_range(0, 1) == 0 || len <= cur_max) len = cur_max + 1;
    end else begin
      bad = 1'b0;
      cap = (cur_max < 24) ? cur_max : 24;
      len = $urandom_range(1, cap);
      if ($urandom_range(0, 99) < 4)
        len = (cur_max < 300) ? cur_max : $urandom_range(25, 300);
    end
    surplus = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < 4; i++)
      push_data(len[8*i +: 8], (bad && i == 3) ? (surplus == 0) : ($urandom_range(0, 3) == 0));
    if (!bad) begin
      n_pay = len;
      if ($urandom_range(0, 99) < 8) n_pay = $urandom_range(0, len - 1);
      for (int unsigned i = 0; i < n_pay; i++)
        push_data(8'($urandom_range(0, 255)),
                  (i == len - 1) ? (surplus == 0) : ($urandom_range(0, 3) == 0));
      if (n_pay < len) begin
        push_clear();
        return;
      end
    end
    for (int unsigned i = 0; i < surplus; i++)
      push_data(8'($urandom_range(0, 255)), i == surplus - 1);
    // a late chunk after the frame ended is rejected
    if ($urandom_range(0, 3) == 0) begin
      n_pay = $urandom_range(1, 3);
      for (int unsigned i = 0; i < n_pay; i++)
        push_data(8'($urandom_range(0, 255)), i == n_pay - 1);
    end
    if ($urandom_range(0, 9) != 0) push_clear();
  endtask

  // receiver side: random ready pattern plus one long hold-off on request
  initial begin
    int run;
    int hold_cnt;
    bit rdy;
    out_chan.ready = 1'b0;
    run = 0;
    rdy = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_chan.ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        rx_hold = 1'b0;
        rdy = 1'b0;
        run = 0;
      end
      if (run == 0) begin
        rdy = !rdy;
        run = rdy ? ready_run() : stall_len();
      end
      run--;
      out_chan.ready <= rdy;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still expected", cycle_count, outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [31:0] limits [6];
    int          start;
    in_chan.valid      = 1'b0;
    in_chan.kind       = KIND_DATA;
    in_chan.data_byte  = '0;
    in_chan.chunk_last = 1'b0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.data      = '0;
    items_sent  = 0;
    clears_sent = 0;
    cfg_writes  = 0;
    no_gaps     = 1'b0;
    rx_hold     = 1'b0;
    cur_max     = MAX_PAYLOAD_RST;
    rst_n       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // length 4097 against the reset limit; byte after the prefix in the same chunk is dropped
    push_data(8'h01, 1'b0);
    push_data(8'h10, 1'b0);
    push_data(8'h00, 1'b0);
    push_data(8'h00, 1'b0);
    push_data(8'hFF, 1'b1);
    push_clear();
    // zero length
    repeat (3) push_data(8'h00, 1'b0);
    push_data(8'h00, 1'b1);
    push_clear();
    // two-byte frame over several chunks, surplus byte, then a late chunk
    push_data(8'h02, 1'b0);
    push_data(8'h00, 1'b1);
    push_data(8'h00, 1'b0);
    push_data(8'h00, 1'b0);
    push_data(8'hFF, 1'b0);
    push_data(8'h00, 1'b0);
    push_data(8'h55, 1'b1);
    push_data(8'h77, 1'b1);
    // clear in the middle of a chunk
    push_data(8'h03, 1'b0);
    push_clear();
    // largest length with the largest limit
    set_max_payload(32'hFFFF_FFFF);
    repeat (3) push_data(8'hFF, 1'b0);
    push_data(8'hFF, 1'b1);
    push_data(8'hA5, 1'b1);
    push_clear();
    // zero limit: any nonzero length is too large
    set_max_payload(32'd0);
    push_data(8'h01, 1'b0);
    repeat (2) push_data(8'h00, 1'b0);
    push_data(8'h00, 1'b1);
    push_clear();

    limits = '{32'd4096, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd200, 32'd0};
    for (int p = 0; p < 6; p++) begin
      set_max_payload((p == 5) ? 32'($urandom_range(2, 30)) : limits[p]);
      start = items_sent;
      if (p == 0) begin
        rx_hold = 1'b1;
        no_gaps = 1'b1;
      end
      while (items_sent - start < PHASE_ITEMS) begin
        random_frame();
        if (items_sent - start > 40) no_gaps = 1'b0;
      end
    end

    settle();
    $display("Ran %0d byte transactions (%0d clears) over %0d max_payload settings.",
             items_sent, clears_sent, cfg_writes);
    $display("Checked %0d results: %0d payload bytes, %0d frames done, %0d invalid, %0d too large.",
             n_results, n_payload, n_frames, n_invalid, n_too_large);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/lpfr_pkg.sv
rtl/lpfr_ifs.sv
rtl/lpfr_core.sv
rtl/lpfr_skid.sv
rtl/length_prefixed_frame_receiver.sv
rtl/lpfr_chk.sv
verif/lpfr_checker.sv
verif/tb_top.sv
